FILE: rtl/art_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and channel codes for the ratiometric ADC telemetry core.
// No dependencies; every other file imports this package.
package art_pkg;

    localparam int KIND_W    = 2;
    localparam int SAMPLE_W  = 12;
    localparam int AVG_W     = 12;
    localparam int SUPPLY_W  = 23;
    localparam int READING_W = 25;
    localparam int OFFSET_W  = 10;

    localparam int AVG_COUNT_DEF = 8;
    localparam int MAX_SAMPLE    = 4095;

    // Serial multiplier: supply or temperature difference times average or slope
    localparam int MUL_A_W   = SUPPLY_W;
    localparam int MUL_B_W   = AVG_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    // Serial divider: widest dividend is the supply-scaled product
    localparam int DIV_W     = PROD_W;
    localparam int DVS_W     = 12;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Temperature path: |1430 - mv| * 100 fits in this many bits
    localparam int TPROD_W   = 30;
    localparam int TQUO_W    = 24;

    localparam int REF_NUM_W = 23;
    localparam logic [REF_NUM_W-1:0] REF_NUM      = 23'd4914000;  // 1200 * 4095
    localparam logic [SUPPLY_W-1:0]  SUPPLY_RESET = 23'd3300;
    localparam logic [DVS_W-1:0]     FULL_SCALE   = 12'd4095;
    localparam logic [SUPPLY_W-1:0]  T_SENSOR_MV  = 23'd1430;
    localparam logic [MUL_B_W-1:0]   T_SLOPE_NUM  = 12'd100;
    localparam logic [DVS_W-1:0]     T_SLOPE_DEN  = 12'd43;
    localparam logic signed [READING_W-1:0] T_BASE_TENTHS = 25'sd250;

    localparam logic [KIND_W-1:0] KIND_REF  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CUR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TEMP = 2'd3;

endpackage

FILE: rtl/art_accum.sv
`timescale 1ns / 1ps
// Per-channel sample accumulators and group counters for the telemetry core.
// Depends on art_pkg.
module art_accum import art_pkg::*; #(
    parameter int  AVERAGE_COUNT = AVG_COUNT_DEF,
    localparam int SUM_W         = $clog2(MAX_SAMPLE * AVERAGE_COUNT + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [KIND_W-1:0]   kind,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                group_done,
    output logic [SUM_W-1:0]    group_sum
);

    localparam int CNT_W  = (AVERAGE_COUNT > 1) ? $clog2(AVERAGE_COUNT) : 1;
    localparam int CHAN_N = 1 << KIND_W;

    logic [SUM_W-1:0] sum_reg [CHAN_N];
    logic [CNT_W-1:0] cnt_reg [CHAN_N];

    assign group_sum  = sum_reg[kind] + SUM_W'(sample);
    assign group_done = (cnt_reg[kind] == CNT_W'(AVERAGE_COUNT - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHAN_N; i++) begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else if (wr_en) begin
            // restart the channel once its group is complete
            if (group_done) begin
                sum_reg[kind] <= '0;
                cnt_reg[kind] <= '0;
            end else begin
                sum_reg[kind] <= group_sum;
                cnt_reg[kind] <= cnt_reg[kind] + CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/art_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on art_pkg.
module art_mul import art_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_A_W-1:0] mcand,
    input  logic [MUL_B_W-1:0] mplier,
    output logic               done,
    output logic [PROD_W-1:0]  product
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MUL_A_W-1:0]   mcand_reg, mcand_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [MUL_A_W:0]     part_sum;

    // add into the upper half, then shift the whole product right one bit
    assign part_sum = {1'b0, acc_reg[PROD_W-1:MUL_B_W]}
                    + (acc_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = MUL_CNT_W'(MUL_B_W);
            mcand_next = mcand;
            acc_next   = {{MUL_A_W{1'b0}}, mplier};
        end else if (busy_reg) begin
            acc_next = PROD_W'({part_sum, acc_reg[MUL_B_W-1:0]} >> 1);
            cnt_next = cnt_reg - MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg   <= cnt_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/art_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Dividend arrives left-aligned with nbits significant bits. Depends on art_pkg.
module art_div import art_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DVS_W-1:0]     divisor,
    input  logic [DIV_CNT_W-1:0] nbits,
    output logic                 done,
    output logic [DIV_W-1:0]     quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVS_W:0]       shifted;
    logic [DVS_W+1:0]     diff;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !diff[DVS_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = nbits;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/adc_ratiometric_telemetry_core.sv
`timescale 1ns / 1ps
// Ratiometric ADC telemetry core: per-channel oversampling, supply tracking and scaling.
// One item at a time; a sample that does not complete a group leaves the core idle.
// Closing a group runs the serial units (one bit per cycle): average divide, then for
// the reference REF_NUM/average (skipped on a zero average), else supply*avg/4095 and
// for temperature |1430-mv|*100/43. The result register frees the input side.
// Reset clears sums, counts and offset, and sets the stored supply to 3300 mV.
module adc_ratiometric_telemetry_core import art_pkg::*; #(
    parameter int AVERAGE_COUNT = AVG_COUNT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic signed [OFFSET_W-1:0] cfg_wdata,   // temp_offset_tenths
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,     // [11:0] sample
    input  logic [KIND_W-1:0]          s_tuser,     // [1:0] kind
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,     // [24:0] reading
    output logic [KIND_W-1:0]          m_tuser      // [1:0] quantity
);

    localparam int SUM_W = $clog2(MAX_SAMPLE * AVERAGE_COUNT + 1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_AVG_LD   = 4'd1;
    localparam logic [3:0] ST_AVG_RUN  = 4'd2;
    localparam logic [3:0] ST_REF_LD   = 4'd3;
    localparam logic [3:0] ST_REF_RUN  = 4'd4;
    localparam logic [3:0] ST_MUL_LD   = 4'd5;
    localparam logic [3:0] ST_MUL_RUN  = 4'd6;
    localparam logic [3:0] ST_MV_LD    = 4'd7;
    localparam logic [3:0] ST_MV_RUN   = 4'd8;
    localparam logic [3:0] ST_TMUL_LD  = 4'd9;
    localparam logic [3:0] ST_TMUL_RUN = 4'd10;
    localparam logic [3:0] ST_TDIV_LD  = 4'd11;
    localparam logic [3:0] ST_TDIV_RUN = 4'd12;
    localparam logic [3:0] ST_OUT      = 4'd13;

    logic [3:0]                 state_reg, state_next;
    logic [KIND_W-1:0]          kind_reg, kind_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [AVG_W-1:0]           avg_reg, avg_next;
    logic [SUPPLY_W-1:0]        supply_reg, supply_next;
    logic [SUPPLY_W-1:0]        work_reg, work_next;
    logic                       neg_reg, neg_next;
    logic [READING_W-1:0]       result_reg, result_next;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [KIND_W-1:0]          m_tuser_reg, m_tuser_next;
    logic [READING_W-1:0]       m_tdata_reg, m_tdata_next;

    logic                 in_xfer;
    logic                 acc_done;
    logic [SUM_W-1:0]     acc_sum;

    logic                 mul_start, mul_done;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    mul_prod;

    logic                 div_start, div_done;
    logic [DIV_W-1:0]     div_dividend;
    logic [DVS_W-1:0]     div_divisor;
    logic [DIV_CNT_W-1:0] div_nbits;
    logic [DIV_W-1:0]     div_quo;

    logic [AVG_W-1:0]            quo_avg;
    logic [SUPPLY_W-1:0]         quo_mv;
    logic signed [SUPPLY_W:0]    temp_diff;
    logic [TQUO_W-1:0]           quo_temp;
    logic signed [READING_W-1:0] temp_signed;
    logic signed [READING_W-1:0] temp_reading;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    art_accum #(
        .AVERAGE_COUNT(AVERAGE_COUNT)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (in_xfer),
        .kind       (s_tuser),
        .sample     (s_tdata[SAMPLE_W-1:0]),
        .group_done (acc_done),
        .group_sum  (acc_sum)
    );

    art_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    art_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .nbits    (div_nbits),
        .done     (div_done),
        .quotient (div_quo)
    );

    // operand selection for the shared serial units
    always_comb begin
        mul_start    = 1'b0;
        mul_a        = supply_reg;
        mul_b        = avg_reg;
        div_start    = 1'b0;
        div_dividend = DIV_W'(sum_reg) << (DIV_W - SUM_W);
        div_divisor  = DVS_W'(AVERAGE_COUNT);
        div_nbits    = DIV_CNT_W'(SUM_W);
        case (state_reg)
            ST_AVG_LD: begin
                div_start = 1'b1;
            end
            ST_REF_LD: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(REF_NUM) << (DIV_W - REF_NUM_W);
                div_divisor  = avg_reg;
                div_nbits    = DIV_CNT_W'(REF_NUM_W);
            end
            ST_MUL_LD: begin
                mul_start = 1'b1;
            end
            ST_MV_LD: begin
                div_start    = 1'b1;
                div_dividend = mul_prod;
                div_divisor  = FULL_SCALE;
                div_nbits    = DIV_CNT_W'(DIV_W);
            end
            ST_TMUL_LD: begin
                mul_start = 1'b1;
                mul_a     = work_reg;
                mul_b     = T_SLOPE_NUM;
            end
            ST_TDIV_LD: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(mul_prod[TPROD_W-1:0]) << (DIV_W - TPROD_W);
                div_divisor  = T_SLOPE_DEN;
                div_nbits    = DIV_CNT_W'(TPROD_W);
            end
            default: begin
            end
        endcase
    end

    assign quo_avg   = div_quo[AVG_W-1:0];
    assign quo_mv    = div_quo[SUPPLY_W-1:0];
    assign quo_temp  = div_quo[TQUO_W-1:0];
    assign temp_diff = $signed({1'b0, T_SENSOR_MV}) - $signed({1'b0, quo_mv});

    // divide the magnitude, then restore the sign: truncates toward zero
    assign temp_signed  = neg_reg ? -$signed({1'b0, quo_temp}) : $signed({1'b0, quo_temp});
    assign temp_reading = T_BASE_TENTHS + temp_signed + READING_W'(offset_reg);

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        sum_next      = sum_reg;
        avg_next      = avg_reg;
        supply_next   = supply_reg;
        work_next     = work_reg;
        neg_next      = neg_reg;
        result_next   = result_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && acc_done) begin
                    kind_next  = s_tuser;
                    sum_next   = acc_sum;
                    state_next = ST_AVG_LD;
                end
            end
            ST_AVG_LD:  state_next = ST_AVG_RUN;
            ST_AVG_RUN: begin
                if (div_done) begin
                    avg_next = quo_avg;
                    if (kind_reg != KIND_REF) begin
                        state_next = ST_MUL_LD;
                    end else if (quo_avg == '0) begin
                        supply_next = SUPPLY_RESET;
                        result_next = READING_W'(SUPPLY_RESET);
                        state_next  = ST_OUT;
                    end else begin
                        state_next = ST_REF_LD;
                    end
                end
            end
            ST_REF_LD:  state_next = ST_REF_RUN;
            ST_REF_RUN: begin
                if (div_done) begin
                    supply_next = quo_mv;
                    result_next = READING_W'(quo_mv);
                    state_next  = ST_OUT;
                end
            end
            ST_MUL_LD:  state_next = ST_MUL_RUN;
            ST_MUL_RUN: begin
                if (mul_done) begin
                    state_next = ST_MV_LD;
                end
            end
            ST_MV_LD:   state_next = ST_MV_RUN;
            ST_MV_RUN: begin
                if (div_done) begin
                    result_next = READING_W'(quo_mv);
                    neg_next    = temp_diff[SUPPLY_W];
                    work_next   = temp_diff[SUPPLY_W] ? SUPPLY_W'(-temp_diff)
                                                      : SUPPLY_W'(temp_diff);
                    state_next  = (kind_reg == KIND_TEMP) ? ST_TMUL_LD : ST_OUT;
                end
            end
            ST_TMUL_LD:  state_next = ST_TMUL_RUN;
            ST_TMUL_RUN: begin
                if (mul_done) begin
                    state_next = ST_TDIV_LD;
                end
            end
            ST_TDIV_LD:  state_next = ST_TDIV_RUN;
            ST_TDIV_RUN: begin
                if (div_done) begin
                    result_next = temp_reading;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the result register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = kind_reg;
                    m_tdata_next  = result_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            supply_reg   <= SUPPLY_RESET;
            offset_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            supply_reg   <= supply_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                offset_reg <= cfg_wdata;
            end
        end
        kind_reg    <= kind_next;
        sum_reg     <= sum_next;
        avg_reg     <= avg_next;
        work_reg    <= work_next;
        neg_reg     <= neg_next;
        result_reg  <= result_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = {{(32 - READING_W){1'b0}}, m_tdata_reg};

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for adc_ratiometric_telemetry_core: tagged samples in, per-group readings out.
// Predicts group averages, supply tracking and temperature scaling in-bench; needs art_pkg and the core.
module tb_top;
    import art_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int PHASE_SAMPLES  = 475;

    typedef struct packed {
        logic [KIND_W-1:0]    quantity;
        logic [READING_W-1:0] reading;
    } reading_t;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [SAMPLE_W-1:0] sample;
        bit                  typed;
        int                  want;
    } dir_row_t;

    typedef struct {
        int                          src_idle_pct;
        int                          sink_stall_pct;
        logic signed [OFFSET_W-1:0]  offset;
    } phase_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_we;
    logic signed [OFFSET_W-1:0] cfg_wdata;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [15:0]                s_tdata;    // [11:0] sample
    logic [KIND_W-1:0]          s_tuser;    // [1:0] kind
    logic                       m_tvalid;
    logic                       m_tready;
    logic [31:0]                m_tdata;    // [24:0] reading
    logic [KIND_W-1:0]          m_tuser;    // [1:0] quantity

    // Mirror of the core's state
    logic [14:0]                group_sum [4];
    logic [3:0]                 group_cnt [4];
    logic [SUPPLY_W-1:0]        supply_mv;
    logic signed [OFFSET_W-1:0] temp_offset;

    reading_t reading_queue[$];
    reading_t head_reading;

    int src_idle_pct;
    int sink_stall_pct;
    int mismatches;
    int samples_sent;
    int readings_checked;
    int negative_temps;
    int zero_refs;
    int quiet_cycles;

    // Bias of each channel's current random group
    int chan_style [4];
    int chan_left  [4];

    dir_row_t dir_rows [25] = '{
        // supply never measured: full-scale bus reads the reset supply
        '{KIND_BUS, 12'd4095, 1'b0, 0}, '{KIND_BUS, 12'd4095, 1'b0, 0},
        '{KIND_BUS, 12'd4095, 1'b0, 0}, '{KIND_BUS, 12'd4095, 1'b0, 0},
        '{KIND_BUS, 12'd4095, 1'b0, 0}, '{KIND_BUS, 12'd4095, 1'b0, 0},
        '{KIND_BUS, 12'd4095, 1'b0, 0}, '{KIND_BUS, 12'd4095, 1'b1, 3300},
        // reference average truncates to zero: supply falls back to 3300
        '{KIND_REF, 12'd0, 1'b0, 0}, '{KIND_REF, 12'd0, 1'b0, 0},
        '{KIND_REF, 12'd0, 1'b0, 0}, '{KIND_REF, 12'd7, 1'b0, 0},
        '{KIND_REF, 12'd0, 1'b0, 0}, '{KIND_REF, 12'd0, 1'b0, 0},
        '{KIND_REF, 12'd0, 1'b0, 0}, '{KIND_REF, 12'd0, 1'b1, 3300},
        // hot extreme of the temperature sensor
        '{KIND_TEMP, 12'd0, 1'b0, 0}, '{KIND_TEMP, 12'd0, 1'b0, 0},
        '{KIND_TEMP, 12'd0, 1'b0, 0}, '{KIND_TEMP, 12'd0, 1'b0, 0},
        '{KIND_TEMP, 12'd0, 1'b0, 0}, '{KIND_TEMP, 12'd0, 1'b0, 0},
        '{KIND_TEMP, 12'd0, 1'b0, 0}, '{KIND_TEMP, 12'd0, 1'b0, 0},
        '{KIND_CUR, 12'd4095, 1'b0, 0}
    };

    phase_t phases [4] = '{
        '{0,  0,  10'sd511},
        '{83, 0,  -10'sd512},
        '{0,  83, -10'sd500},
        '{27, 27, 10'sd500}
    };

    adc_ratiometric_telemetry_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Fold one sample into its channel; return 1 with the reading when the group closes.
    function automatic bit fold_sample(input logic [KIND_W-1:0] kind,
                                       input logic [SAMPLE_W-1:0] sample,
                                       output reading_t res);
        logic [AVG_W-1:0] avg;
        longint           mv;
        longint           val;
        res = '0;
        group_sum[kind] = group_sum[kind] + sample;
        group_cnt[kind] = group_cnt[kind] + 4'd1;
        if (group_cnt[kind] < AVG_COUNT_DEF)
            return 1'b0;
        avg = AVG_W'(group_sum[kind] / AVG_COUNT_DEF);
        group_sum[kind] = '0;
        group_cnt[kind] = '0;
        mv = (longint'(avg) * longint'(supply_mv)) / longint'(FULL_SCALE);
        case (kind)
            KIND_REF: begin
                if (avg == 0) begin
                    supply_mv = SUPPLY_RESET;
                    zero_refs++;
                end else begin
                    supply_mv = REF_NUM / avg;
                end
                val = longint'(supply_mv);
            end
            KIND_TEMP: begin
                val = longint'(T_BASE_TENTHS)
                    + ((longint'(T_SENSOR_MV) - mv) * longint'(T_SLOPE_NUM))
                      / longint'(T_SLOPE_DEN)
                    + longint'(temp_offset);
                if (val < 0)
                    negative_temps++;
            end
            default: begin
                val = mv;
            end
        endcase
        res.quantity = kind;
        res.reading  = val[READING_W-1:0];
        return 1'b1;
    endfunction

    // Call at a rising edge; returns at the edge where the transfer happens.
    task automatic drive_sample(input logic [KIND_W-1:0] kind, input logic [SAMPLE_W-1:0] sample,
                                input bit typed, input int want);
        reading_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, sample};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        if (fold_sample(kind, sample, res)) begin
            if (typed)
                res.reading = want[READING_W-1:0];
            reading_queue.push_back(res);
        end
    endtask

    task automatic random_sample();
        logic [KIND_W-1:0]   kind;
        logic [SAMPLE_W-1:0] sample;
        kind = KIND_W'($urandom_range(3));
        if (chan_left[kind] == 0) begin
            chan_style[kind] = $urandom_range(5);
            chan_left[kind]  = AVG_COUNT_DEF;
        end
        chan_left[kind]--;
        case (chan_style[kind])
            1:       sample = SAMPLE_W'($urandom_range(3));     // on the reference channel, drives supply to its top
            2:       sample = SAMPLE_W'($urandom_range(4095, 3968));
            3:       sample = $urandom_range(1) ? 12'd4095 : 12'd0;
            4:       sample = SAMPLE_W'($urandom_range(255));
            default: sample = SAMPLE_W'($urandom_range(4095));
        endcase
        drive_sample(kind, sample, 1'b0, 0);
    endtask

    // Drop valid, drain pending readings, let a closing group finish, then write the offset.
    task automatic settle_and_write(input logic signed [OFFSET_W-1:0] offset);
        s_tvalid <= 1'b0;
        while (reading_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wdata <= offset;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        temp_offset  = offset;
    endtask

    // Result side: random stall, check each transfer against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
            if (m_tvalid && m_tready) begin
                if (reading_queue.size() == 0) begin
                    report_mismatch("reading with none pending", $signed(m_tdata[READING_W-1:0]), 0);
                end else begin
                    head_reading = reading_queue.pop_front();
                    readings_checked++;
                    if (m_tuser !== head_reading.quantity)
                        report_mismatch("quantity", m_tuser, head_reading.quantity);
                    if (m_tdata[READING_W-1:0] !== head_reading.reading)
                        report_mismatch("reading", $signed(m_tdata[READING_W-1:0]),
                                        $signed(head_reading.reading));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("adc_ratiometric_telemetry_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        mismatches       = 0;
        samples_sent     = 0;
        readings_checked = 0;
        negative_temps   = 0;
        zero_refs        = 0;
        quiet_cycles     = 0;
        for (int i = 0; i < 4; i++) begin
            group_sum[i]  = '0;
            group_cnt[i]  = '0;
            chan_style[i] = 0;
            chan_left[i]  = 0;
        end
        supply_mv   = SUPPLY_RESET;
        temp_offset = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            drive_sample(dir_rows[i].kind, dir_rows[i].sample, dir_rows[i].typed,
                         dir_rows[i].want);

        foreach (phases[p]) begin
            settle_and_write(phases[p].offset);
            src_idle_pct   = phases[p].src_idle_pct;
            sink_stall_pct = phases[p].sink_stall_pct;
            repeat (PHASE_SAMPLES) random_sample();
        end

        s_tvalid <= 1'b0;
        while (reading_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("sent %0d samples over 4 pacing phases, checked %0d readings", samples_sent,
                 readings_checked);
        $display("offsets -512..511 applied; %0d zero reference groups, %0d sub-zero temperatures",
                 zero_refs, negative_temps);
        if (mismatches == 0) begin
            $display("adc_ratiometric_telemetry_core verification clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("adc_ratiometric_telemetry_core verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/art_pkg.sv
rtl/art_accum.sv
rtl/art_mul.sv
rtl/art_div.sv
rtl/adc_ratiometric_telemetry_core.sv
tb/tb_top.sv
